// ----- hw/rtl/mvwt_pkg.sv -----
// shared types and constants of the vertex weld and triangulate block
`default_nettype none

package mvwt_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int INDEX_BITS_DEF  = 21;

    localparam int IN_W        = 21;
    localparam int ID_OUT_W    = 12;
    localparam int MAT_W       = 11;
    localparam int MAX_CORNERS = 4;
    localparam int CNT_W       = 3;
    localparam int S_DATA_W    = 144;
    localparam int M_DATA_W    = 128;

    localparam logic [1:0] KIND_CORNER = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FULL = 2'd1;
    localparam logic [1:0] ERR_MANY = 2'd2;
    localparam logic [1:0] ERR_FEW  = 2'd3;

    typedef enum logic [2:0] {
        SEL_CORNER_HIT,
        SEL_CORNER_NEW,
        SEL_ERR_FULL,
        SEL_ERR_MANY,
        SEL_ERR_FEW,
        SEL_TRI0,
        SEL_TRI1
    } out_sel_t;

    typedef struct packed {
        logic     latch;
        logic     clr_wr;
        logic     probe_start;
        logic     probe_next;
        logic     insert;
        logic     push_hit;
        logic     set_bad;
        logic     clr_face;
        logic     load_out;
        out_sel_t sel;
        logic     last;
    } cmd_t;

    typedef struct packed {
        logic addr_max;
        logic hit;
        logic empty;
        logic full;
        logic many;
        logic few;
        logic four;
        logic bad;
        logic fe;
        logic out_done;
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mvwt_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module mvwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mvwt_dp.sv -----
// datapath: index resolve, hashed key table, corner store and result register
`default_nettype none

module mvwt_dp
    import mvwt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_DATA_W-1:0]   m_tdata,
    output logic      [1:0]            m_tuser,
    output logic                       m_tlast
);

    localparam int ID_W   = $clog2(TABLE_DEPTH);
    localparam int NID_W  = ID_W + 1;
    localparam int HASH_W = ID_W + 1;
    localparam int SLOTS  = 2 ** HASH_W;
    localparam int KEY_W  = 3 * INDEX_BITS;
    localparam int ENT_W  = 1 + KEY_W + ID_W;

    function automatic logic [INDEX_BITS-1:0] resolve(input logic [IN_W-1:0] raw,
                                                      input logic [IN_W-1:0] cnt);
        logic [IN_W:0] x;
        if (raw == '0) begin
            x = '1;
        end else if (raw[IN_W-1]) begin
            x = {1'b0, cnt} + {raw[IN_W-1], raw};
        end else begin
            x = {raw[IN_W-1], raw} - (IN_W+1)'(1);
        end
        return x[INDEX_BITS-1:0];
    endfunction

    function automatic logic [IN_W-1:0] key_ext(input logic [INDEX_BITS-1:0] k);
        return IN_W'(signed'(k));
    endfunction

    function automatic logic [ID_OUT_W-1:0] id_out(input logic [ID_W-1:0] id);
        logic [ID_W+ID_OUT_W-1:0] t;
        t = {{ID_OUT_W{1'b0}}, id};
        return t[ID_OUT_W-1:0];
    endfunction

    logic [KEY_W-1:0]    key_reg;
    logic [MAT_W-1:0]    mat_reg;
    logic                fe_reg;
    logic [HASH_W-1:0]   addr_reg;
    logic [HASH_W-1:0]   addr_next;
    logic [NID_W-1:0]    next_id_reg;
    logic [ID_OUT_W-1:0] corner_id_reg [MAX_CORNERS];
    logic [CNT_W-1:0]    count_reg;
    logic                bad_reg;
    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg;

    logic [HASH_W-1:0]   hash;
    logic                ram_we;
    logic [ENT_W-1:0]    ram_wdata;
    logic [ENT_W-1:0]    ram_rdata;
    logic                rd_valid;
    logic [KEY_W-1:0]    rd_key;
    logic [ID_W-1:0]     rd_id;
    logic [KEY_W-1:0]    key_in;

    logic [1:0]          o_kind;
    logic [ID_OUT_W-1:0] o_vid;
    logic                o_new;
    logic                o_keys;
    logic [ID_OUT_W-1:0] o_a;
    logic [ID_OUT_W-1:0] o_b;
    logic [ID_OUT_W-1:0] o_c;
    logic [MAT_W-1:0]    o_mat;
    logic [1:0]          o_err;
    logic [IN_W-1:0]     o_kp;
    logic [IN_W-1:0]     o_kn;
    logic [IN_W-1:0]     o_kt;

    assign key_in = {resolve(s_tdata[62:42], s_tdata[125:105]),
                     resolve(s_tdata[41:21], s_tdata[104:84]),
                     resolve(s_tdata[20:0], s_tdata[83:63])};

    // fold the packed key onto the slot index
    always_comb begin
        hash = '0;
        for (int i = 0; i < KEY_W; i++) begin
            hash[i % HASH_W] = hash[i % HASH_W] ^ key_reg[i];
        end
    end

    assign ram_we    = cmd.clr_wr | cmd.insert;
    assign ram_wdata = cmd.clr_wr ? '0 : {1'b1, key_reg, next_id_reg[ID_W-1:0]};

    mvwt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    assign rd_valid = ram_rdata[ENT_W-1];
    assign rd_key   = ram_rdata[ENT_W-2 -: KEY_W];
    assign rd_id    = ram_rdata[ID_W-1:0];

    assign status.addr_max = (addr_reg == '1);
    assign status.hit      = rd_valid && (rd_key == key_reg);
    assign status.empty    = !rd_valid;
    assign status.full     = (next_id_reg == NID_W'(TABLE_DEPTH));
    assign status.many     = (count_reg >= CNT_W'(MAX_CORNERS));
    assign status.few      = (count_reg < CNT_W'(3));
    assign status.four     = (count_reg == CNT_W'(MAX_CORNERS));
    assign status.bad      = bad_reg;
    assign status.fe       = fe_reg;
    assign status.out_done = out_valid_reg && m_tready;

    always_comb begin
        addr_next = addr_reg;
        if (cmd.probe_start) begin
            addr_next = hash;
        end else if (cmd.probe_next || cmd.clr_wr) begin
            addr_next = addr_reg + HASH_W'(1);
        end
    end

    always_comb begin
        o_kind = KIND_CORNER;
        o_vid  = '0;
        o_new  = 1'b0;
        o_keys = 1'b0;
        o_a    = '0;
        o_b    = '0;
        o_c    = '0;
        o_mat  = '0;
        o_err  = ERR_NONE;
        case (cmd.sel)
            SEL_CORNER_HIT: begin
                o_vid  = id_out(rd_id);
                o_keys = 1'b1;
            end
            SEL_CORNER_NEW: begin
                o_vid  = id_out(next_id_reg[ID_W-1:0]);
                o_new  = 1'b1;
                o_keys = 1'b1;
            end
            SEL_ERR_FULL: begin
                o_kind = KIND_ERR;
                o_keys = 1'b1;
                o_err  = ERR_FULL;
            end
            SEL_ERR_MANY: begin
                o_kind = KIND_ERR;
                o_keys = 1'b1;
                o_err  = ERR_MANY;
            end
            SEL_ERR_FEW: begin
                o_kind = KIND_ERR;
                o_err  = ERR_FEW;
            end
            SEL_TRI0: begin
                o_kind = KIND_TRI;
                o_a    = corner_id_reg[0];
                o_b    = corner_id_reg[1];
                o_c    = corner_id_reg[2];
                o_mat  = mat_reg;
            end
            SEL_TRI1: begin
                o_kind = KIND_TRI;
                o_a    = corner_id_reg[0];
                o_b    = corner_id_reg[2];
                o_c    = corner_id_reg[3];
                o_mat  = mat_reg;
            end
            default: begin
                o_kind = KIND_ERR;
            end
        endcase
        o_kp = o_keys ? key_ext(key_reg[INDEX_BITS-1:0]) : '0;
        o_kn = o_keys ? key_ext(key_reg[2*INDEX_BITS-1:INDEX_BITS]) : '0;
        o_kt = o_keys ? key_ext(key_reg[KEY_W-1:2*INDEX_BITS]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            next_id_reg   <= '0;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CORNERS; i++) begin
                corner_id_reg[i] <= '0;
            end
        end else begin
            addr_reg <= addr_next;
            if (cmd.insert) begin
                next_id_reg <= next_id_reg + NID_W'(1);
            end
            if (cmd.insert) begin
                corner_id_reg[count_reg[1:0]] <= id_out(next_id_reg[ID_W-1:0]);
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.push_hit) begin
                corner_id_reg[count_reg[1:0]] <= id_out(rd_id);
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.clr_face) begin
                count_reg <= '0;
            end
            if (cmd.clr_face) begin
                bad_reg <= 1'b0;
            end else if (cmd.set_bad) begin
                bad_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            key_reg <= key_in;
            mat_reg <= s_tdata[136:126];
            fe_reg  <= s_tlast;
        end
        if (cmd.load_out) begin
            out_kind_reg <= o_kind;
            out_last_reg <= cmd.last;
            out_data_reg <= {3'b000, o_err, o_mat, o_c, o_b, o_a, o_kt, o_kn, o_kp,
                             o_new, o_vid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_id_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg <= NID_W'(TABLE_DEPTH))
        else $error("vertex id counter beyond table depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !out_valid_reg)
        else $error("result register loaded while a word is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_CORNERS))
        else $error("corner count beyond limit");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mvwt_ctrl.sv -----
// controller: table clearing, probe sequencing and result ordering
`default_nettype none

module mvwt_ctrl
    import mvwt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_CMP,
        ST_OUT,
        ST_FEND,
        ST_TRI2
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.sel    = SEL_CORNER_HIT;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.addr_max) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.bad) begin
                    state_next = ST_FEND;
                end else if (status.many) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SEL_ERR_MANY;
                    cmd.last     = 1'b1;
                    cmd.set_bad  = 1'b1;
                    ret_next     = ST_FEND;
                    state_next   = ST_OUT;
                end else begin
                    cmd.probe_start = 1'b1;
                    state_next      = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (status.hit) begin
                    cmd.push_hit = 1'b1;
                    cmd.load_out = 1'b1;
                    cmd.sel      = SEL_CORNER_HIT;
                    cmd.last     = !status.fe;
                    ret_next     = ST_FEND;
                    state_next   = ST_OUT;
                end else if (status.empty) begin
                    cmd.load_out = 1'b1;
                    ret_next     = ST_FEND;
                    state_next   = ST_OUT;
                    if (status.full) begin
                        cmd.set_bad = 1'b1;
                        cmd.sel     = SEL_ERR_FULL;
                        cmd.last    = 1'b1;
                    end else begin
                        cmd.insert = 1'b1;
                        cmd.sel    = SEL_CORNER_NEW;
                        cmd.last   = !status.fe;
                    end
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_OUT: begin
                if (status.out_done) begin
                    state_next = ret_reg;
                end
            end
            ST_FEND: begin
                if (!status.fe) begin
                    state_next = ST_IDLE;
                end else if (status.bad) begin
                    cmd.clr_face = 1'b1;
                    state_next   = ST_IDLE;
                end else if (status.few) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SEL_ERR_FEW;
                    cmd.last     = 1'b1;
                    cmd.clr_face = 1'b1;
                    ret_next     = ST_IDLE;
                    state_next   = ST_OUT;
                end else begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SEL_TRI0;
                    cmd.last     = !status.four;
                    state_next   = ST_OUT;
                    if (status.four) begin
                        ret_next = ST_TRI2;
                    end else begin
                        cmd.clr_face = 1'b1;
                        ret_next     = ST_IDLE;
                    end
                end
            end
            ST_TRI2: begin
                cmd.load_out = 1'b1;
                cmd.sel      = SEL_TRI1;
                cmd.last     = 1'b1;
                cmd.clr_face = 1'b1;
                ret_next     = ST_IDLE;
                state_next   = ST_OUT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.latch)
        else $error("input taken outside idle");

    a_probe_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_CMP))
        else $error("read not followed by compare");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert && cmd.clr_wr))
        else $error("insert during clearing pass");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mesh_vertex_weld_triangulate.sv -----
// Face corners in, welded vertex ids and fan triangles out. Each corner's
// indices are resolved and looked up in an open-addressed hash table of
// 2 ** ($clog2(TABLE_DEPTH) + 1) slots (8192 by default) in one RAM; a
// corner's slot is read and compared, and a collision probes on to the
// adjacent slot. Each result word waits for the output handshake, and a
// four-corner face adds a second triangle. A corner of a face already in
// error only checks for the face end, a corner beyond the fourth gives its
// error word. After reset the table is cleared one slot per cycle before
// any corner is taken. Results leave through a registered output stage.
`default_nettype none

module mesh_vertex_weld_triangulate
    import mvwt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // raw_pos_index, raw_nor_index, raw_tex_index, pos_count, nor_count,
    // tex_count, material
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // vertex_id, is_new, key_pos, key_nor, key_tex, tri_a, tri_b, tri_c,
    // tri_material, error_code
    output logic      [M_DATA_W-1:0] m_tdata,
    // kind
    output logic      [1:0]          m_tuser,
    output logic                     m_tlast
);

    cmd_t    cmd;
    status_t status;

    mvwt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mvwt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
